// ===== sv/hmsi_pkg.sv =====
// hmsi_pkg.sv: shared types, constants and the micro-program of the spring integrator
`timescale 1ns / 1ps

package hmsi_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  // numerator width of the serial divider
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int CNT_W     = $clog2(NUM_W + 1);

  localparam logic signed [31:0] Q_MAX_C = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN_C = 32'sh80000000;
  // gravity, 9.81 rounded to the fixed point grid
  localparam longint GRAV_L = (981 * (64'sd1 <<< FRAC_BITS) + 50) / 100;
  localparam logic signed [31:0] GRAV_Q = GRAV_L[31:0];

  // register indexes of the configuration port
  localparam logic [2:0] CFG_STIFFNESS   = 3'd0;
  localparam logic [2:0] CFG_MASS        = 3'd1;
  localparam logic [2:0] CFG_DAMPING     = 3'd2;
  localparam logic [2:0] CFG_REST_LENGTH = 3'd3;
  localparam logic [2:0] CFG_GROUND_K    = 3'd4;
  localparam logic [2:0] CFG_TIME_STEP   = 3'd5;
  localparam logic [2:0] CFG_METHOD      = 3'd6;
  localparam logic [2:0] CFG_GROUND_EN   = 3'd7;

  // integrator codes
  localparam logic [2:0] METH_EXPLICIT   = 3'd1;
  localparam logic [2:0] METH_SYMPLECTIC = 3'd2;
  localparam logic [2:0] METH_MIDPOINT   = 3'd3;
  localparam logic [2:0] METH_IMPLICIT   = 3'd4;
  localparam logic [2:0] METH_VERLET     = 3'd5;

  // input command codes
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // number of micro-ops in one force evaluation
  localparam logic [4:0] FORCE_LEN = 5'd11;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_GTST
  } alu_e;

  typedef enum logic [4:0] {
    OP_ZERO,
    OP_P,
    OP_V,
    OP_PREV,
    OP_ANCH,
    OP_K,
    OP_M,
    OP_D,
    OP_L,
    OP_KC,
    OP_DT,
    OP_HDT,
    OP_GRAV,
    OP_T0,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_T4
  } opnd_e;

  typedef enum logic [2:0] {
    DST_P,
    DST_V,
    DST_PREV,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3,
    DST_T4
  } dst_e;

  typedef struct packed {
    alu_e  alu;
    dst_e  dst;
    opnd_e a;
    opnd_e b;
    logic  cond;   // skipped unless the ground flag is set
    logic  last;   // final op of the program
  } uop_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic clr;
    logic start;
    logic emit;
    uop_t uop;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       done;
    logic [2:0] method;
  } dp_sts_t;

  typedef struct packed {
    logic              flag;
    logic signed [31:0] val;
  } sat_t;

  // clamp to the signed 32-bit range
  function automatic sat_t sat64(logic signed [63:0] x);
    sat_t r;
    if (x > 64'sd2147483647) begin
      r.flag = 1'b1;
      r.val  = Q_MAX_C;
    end else if (x < -64'sd2147483648) begin
      r.flag = 1'b1;
      r.val  = Q_MIN_C;
    end else begin
      r.flag = 1'b0;
      r.val  = x[31:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(alu_e al, dst_e d, opnd_e a, opnd_e b, logic c, logic l);
    uop_t u;
    u.alu  = al;
    u.dst  = d;
    u.a    = a;
    u.b    = b;
    u.cond = c;
    u.last = l;
    return u;
  endfunction

  // force on the mass at position p and velocity v, left in T0, T1 as scratch
  function automatic uop_t force_uop(logic [3:0] i, opnd_e p, opnd_e v);
    uop_t u;
    u = mk(ALU_ADD, DST_T0, OP_T0, OP_ZERO, 1'b0, 1'b1);
    unique case (i)
      4'd0:    u = mk(ALU_MUL,  DST_T0, OP_M,    OP_GRAV, 1'b0, 1'b0);
      4'd1:    u = mk(ALU_SUB,  DST_T0, OP_ZERO, OP_T0,   1'b0, 1'b0);
      4'd2:    u = mk(ALU_SUB,  DST_T1, p,       OP_ANCH, 1'b0, 1'b0);
      4'd3:    u = mk(ALU_ADD,  DST_T1, OP_T1,   OP_L,    1'b0, 1'b0);
      4'd4:    u = mk(ALU_MUL,  DST_T1, OP_K,    OP_T1,   1'b0, 1'b0);
      4'd5:    u = mk(ALU_SUB,  DST_T0, OP_T0,   OP_T1,   1'b0, 1'b0);
      4'd6:    u = mk(ALU_MUL,  DST_T1, OP_D,    v,       1'b0, 1'b0);
      4'd7:    u = mk(ALU_SUB,  DST_T0, OP_T0,   OP_T1,   1'b0, 1'b0);
      4'd8:    u = mk(ALU_GTST, DST_T1, p,       OP_ZERO, 1'b0, 1'b0);
      4'd9:    u = mk(ALU_MUL,  DST_T1, OP_KC,   p,       1'b1, 1'b0);
      4'd10:   u = mk(ALU_SUB,  DST_T0, OP_T0,   OP_T1,   1'b1, 1'b0);
      default: u = mk(ALU_ADD,  DST_T0, OP_T0,   OP_ZERO, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

  // micro-program: a force evaluation followed by the integrator tail
  function automatic uop_t prog_uop(logic [2:0] method, logic [4:0] step);
    uop_t       u;
    logic [4:0] j;
    j = step - FORCE_LEN;
    u = mk(ALU_ADD, DST_T0, OP_T0, OP_ZERO, 1'b0, 1'b1);
    if (step < FORCE_LEN) begin
      u = force_uop(step[3:0], OP_P, OP_V);
    end else begin
      unique case (method)
        METH_EXPLICIT: begin
          unique case (j)
            5'd0:    u = mk(ALU_DIV, DST_T0, OP_T0, OP_M,  1'b0, 1'b0);
            5'd1:    u = mk(ALU_MUL, DST_T2, OP_DT, OP_V,  1'b0, 1'b0);
            5'd2:    u = mk(ALU_ADD, DST_P,  OP_P,  OP_T2, 1'b0, 1'b0);
            5'd3:    u = mk(ALU_MUL, DST_T1, OP_DT, OP_T0, 1'b0, 1'b0);
            5'd4:    u = mk(ALU_ADD, DST_V,  OP_V,  OP_T1, 1'b0, 1'b1);
            default: u = mk(ALU_ADD, DST_T0, OP_T0, OP_ZERO, 1'b0, 1'b1);
          endcase
        end
        METH_SYMPLECTIC: begin
          unique case (j)
            5'd0:    u = mk(ALU_DIV, DST_T0, OP_T0, OP_M,  1'b0, 1'b0);
            5'd1:    u = mk(ALU_MUL, DST_T1, OP_DT, OP_T0, 1'b0, 1'b0);
            5'd2:    u = mk(ALU_ADD, DST_V,  OP_V,  OP_T1, 1'b0, 1'b0);
            5'd3:    u = mk(ALU_MUL, DST_T1, OP_DT, OP_V,  1'b0, 1'b0);
            5'd4:    u = mk(ALU_ADD, DST_P,  OP_P,  OP_T1, 1'b0, 1'b1);
            default: u = mk(ALU_ADD, DST_T0, OP_T0, OP_ZERO, 1'b0, 1'b1);
          endcase
        end
        METH_MIDPOINT: begin
          // second force at the half step point held in T3 and T2
          if (j >= 5'd5 && j <= 5'd15) begin
            u = force_uop(4'(j - 5'd5), OP_T3, OP_T2);
          end else begin
            unique case (j)
              5'd0:    u = mk(ALU_DIV, DST_T0, OP_T0,  OP_M,  1'b0, 1'b0);
              5'd1:    u = mk(ALU_MUL, DST_T1, OP_HDT, OP_T0, 1'b0, 1'b0);
              5'd2:    u = mk(ALU_ADD, DST_T2, OP_V,   OP_T1, 1'b0, 1'b0);
              5'd3:    u = mk(ALU_MUL, DST_T1, OP_HDT, OP_V,  1'b0, 1'b0);
              5'd4:    u = mk(ALU_ADD, DST_T3, OP_P,   OP_T1, 1'b0, 1'b0);
              5'd16:   u = mk(ALU_DIV, DST_T0, OP_T0,  OP_M,  1'b0, 1'b0);
              5'd17:   u = mk(ALU_MUL, DST_T1, OP_DT,  OP_T2, 1'b0, 1'b0);
              5'd18:   u = mk(ALU_ADD, DST_P,  OP_P,   OP_T1, 1'b0, 1'b0);
              5'd19:   u = mk(ALU_MUL, DST_T1, OP_DT,  OP_T0, 1'b0, 1'b0);
              5'd20:   u = mk(ALU_ADD, DST_V,  OP_V,   OP_T1, 1'b0, 1'b1);
              default: u = mk(ALU_ADD, DST_T0, OP_T0,  OP_ZERO, 1'b0, 1'b1);
            endcase
          end
        end
        METH_IMPLICIT: begin
          unique case (j)
            5'd0:    u = mk(ALU_MUL, DST_T1, OP_DT, OP_D,    1'b0, 1'b0);
            5'd1:    u = mk(ALU_ADD, DST_T2, OP_M,  OP_T1,   1'b0, 1'b0);
            5'd2:    u = mk(ALU_MUL, DST_T3, OP_DT, OP_DT,   1'b0, 1'b0);
            5'd3:    u = mk(ALU_ADD, DST_T4, OP_K,  OP_ZERO, 1'b0, 1'b0);
            5'd4:    u = mk(ALU_ADD, DST_T4, OP_T4, OP_KC,   1'b1, 1'b0);
            5'd5:    u = mk(ALU_MUL, DST_T3, OP_T3, OP_T4,   1'b0, 1'b0);
            5'd6:    u = mk(ALU_ADD, DST_T3, OP_T2, OP_T3,   1'b0, 1'b0);
            5'd7:    u = mk(ALU_MUL, DST_T2, OP_T2, OP_V,    1'b0, 1'b0);
            5'd8:    u = mk(ALU_MUL, DST_T1, OP_DT, OP_T0,   1'b0, 1'b0);
            5'd9:    u = mk(ALU_ADD, DST_T2, OP_T2, OP_T1,   1'b0, 1'b0);
            5'd10:   u = mk(ALU_DIV, DST_V,  OP_T2, OP_T3,   1'b0, 1'b0);
            5'd11:   u = mk(ALU_MUL, DST_T1, OP_DT, OP_V,    1'b0, 1'b0);
            5'd12:   u = mk(ALU_ADD, DST_P,  OP_P,  OP_T1,   1'b0, 1'b1);
            default: u = mk(ALU_ADD, DST_T0, OP_T0, OP_ZERO, 1'b0, 1'b1);
          endcase
        end
        METH_VERLET: begin
          unique case (j)
            5'd0:    u = mk(ALU_DIV, DST_T0,   OP_T0, OP_M,    1'b0, 1'b0);
            5'd1:    u = mk(ALU_ADD, DST_T1,   OP_P,  OP_P,    1'b0, 1'b0);
            5'd2:    u = mk(ALU_SUB, DST_T1,   OP_T1, OP_PREV, 1'b0, 1'b0);
            5'd3:    u = mk(ALU_MUL, DST_T2,   OP_DT, OP_DT,   1'b0, 1'b0);
            5'd4:    u = mk(ALU_MUL, DST_T2,   OP_T2, OP_T0,   1'b0, 1'b0);
            5'd5:    u = mk(ALU_ADD, DST_T1,   OP_T1, OP_T2,   1'b0, 1'b0);
            5'd6:    u = mk(ALU_SUB, DST_T2,   OP_T1, OP_PREV, 1'b0, 1'b0);
            5'd7:    u = mk(ALU_ADD, DST_T3,   OP_DT, OP_DT,   1'b0, 1'b0);
            5'd8:    u = mk(ALU_DIV, DST_T2,   OP_T2, OP_T3,   1'b0, 1'b0);
            5'd9:    u = mk(ALU_ADD, DST_PREV, OP_P,  OP_ZERO, 1'b0, 1'b0);
            5'd10:   u = mk(ALU_ADD, DST_P,    OP_T1, OP_ZERO, 1'b0, 1'b0);
            5'd11:   u = mk(ALU_ADD, DST_V,    OP_T2, OP_ZERO, 1'b0, 1'b1);
            default: u = mk(ALU_ADD, DST_T0,   OP_T0, OP_ZERO, 1'b0, 1'b1);
          endcase
        end
        default: u = mk(ALU_ADD, DST_T0, OP_T0, OP_ZERO, 1'b0, 1'b1);
      endcase
    end
    return u;
  endfunction

endpackage

// ===== sv/hmsi_datapath.sv =====
// hmsi_datapath.sv: state, configuration, shared multiplier, adder and serial divider
`timescale 1ns / 1ps

module hmsi_datapath import hmsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_cmd_t           cmd_i,
  output dp_sts_t            sts_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] anchor_pos_i,
  input  logic signed [31:0] load_pos_i,
  input  logic signed [31:0] load_vel_i,
  input  logic signed [31:0] load_prev_pos_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic               saturated_o
);

  // configuration registers
  logic [30:0] k_q, m_q, d_q, l_q, kc_q;
  logic [16:0] dt_q;
  logic [2:0]  method_q;
  logic        gnd_en_q;

  // state and scratch
  logic signed [31:0] p_q, v_q, prev_q, anch_q;
  logic signed [31:0] t0_q, t1_q, t2_q, t3_q, t4_q;
  logic               gnd_q, gnd_d;
  logic               sat_q;

  // multiplier and divider
  logic signed [63:0] prod_q;
  logic               mul_q, mul_d;
  logic               div_q, div_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [31:0]        rem_q, rem_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [31:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic               done_q, done_d;

  // result registers
  logic signed [31:0] pos_q, vel_q;
  logic               satout_q;

  uop_t               u;
  logic signed [31:0] a_val, b_val;
  logic               skip;
  logic               wr_en;
  sat_t               wr_res;
  logic [31:0]        a_mag, b_mag;
  logic [32:0]        trial;
  logic               ge;
  logic signed [63:0] qext;

  assign u = cmd_i.uop;

  function automatic logic signed [31:0] pick(opnd_e s);
    logic signed [31:0] r;
    unique case (s)
      OP_ZERO: r = '0;
      OP_P:    r = p_q;
      OP_V:    r = v_q;
      OP_PREV: r = prev_q;
      OP_ANCH: r = anch_q;
      OP_K:    r = $signed({1'b0, k_q});
      OP_M:    r = $signed({1'b0, m_q});
      OP_D:    r = $signed({1'b0, d_q});
      OP_L:    r = $signed({1'b0, l_q});
      OP_KC:   r = $signed({1'b0, kc_q});
      OP_DT:   r = $signed({15'd0, dt_q});
      OP_HDT:  r = $signed({16'd0, dt_q[16:1]});
      OP_GRAV: r = GRAV_Q;
      OP_T0:   r = t0_q;
      OP_T1:   r = t1_q;
      OP_T2:   r = t2_q;
      OP_T3:   r = t3_q;
      OP_T4:   r = t4_q;
      default: r = '0;
    endcase
    return r;
  endfunction

  // operand selection
  assign a_val = pick(u.a);
  assign b_val = pick(u.b);
  assign skip  = u.cond && !gnd_q;

  assign a_mag = a_val[31] ? 32'(-a_val) : a_val;
  assign b_mag = b_val[31] ? 32'(-b_val) : b_val;

  // one restoring division step
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign qext  = $signed({{(64-NUM_W){1'b0}}, quo_q});

  // op sequencing and result selection
  always_comb begin
    wr_en  = 1'b0;
    wr_res = '0;
    gnd_d  = gnd_q;
    mul_d  = 1'b0;
    div_d  = div_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      if (skip) begin
        done_d = 1'b1;
      end else begin
        unique case (u.alu)
          ALU_ADD: begin
            wr_en  = 1'b1;
            wr_res = sat64(64'(a_val) + 64'(b_val));
            done_d = 1'b1;
          end
          ALU_SUB: begin
            wr_en  = 1'b1;
            wr_res = sat64(64'(a_val) - 64'(b_val));
            done_d = 1'b1;
          end
          ALU_MUL: begin
            mul_d = 1'b1;
          end
          ALU_DIV: begin
            if (b_val == '0) begin
              wr_en       = 1'b1;
              done_d      = 1'b1;
              wr_res.flag = (a_val != '0);
              wr_res.val  = (a_val == '0) ? '0 : (a_val[31] ? Q_MIN_C : Q_MAX_C);
            end else begin
              div_d = 1'b1;
              cnt_d = CNT_W'(NUM_W);
              rem_d = '0;
              quo_d = {a_mag, {FRAC_BITS{1'b0}}};
              den_d = b_mag;
              neg_d = a_val[31] ^ b_val[31];
            end
          end
          ALU_GTST: begin
            gnd_d  = gnd_en_q && a_val[31];
            done_d = 1'b1;
          end
          default: done_d = 1'b1;
        endcase
      end
    end
    if (mul_q) begin
      wr_en  = 1'b1;
      wr_res = sat64(prod_q >>> FRAC_BITS);
      done_d = 1'b1;
    end
    if (div_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
        quo_d = {quo_q[NUM_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end else begin
        wr_en  = 1'b1;
        wr_res = sat64(neg_q ? -qext : qext);
        div_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q    <= 1'b0;
      div_q    <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      gnd_q    <= 1'b0;
      sat_q    <= 1'b0;
      k_q      <= 31'd65536;
      m_q      <= 31'd65536;
      d_q      <= '0;
      l_q      <= 31'd65536;
      kc_q     <= '0;
      dt_q     <= 17'd655;
      method_q <= METH_EXPLICIT;
      gnd_en_q <= 1'b0;
      p_q      <= '0;
      v_q      <= '0;
      prev_q   <= '0;
    end else begin
      mul_q  <= mul_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      gnd_q  <= gnd_d;
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_STIFFNESS:   k_q      <= cfg_data_i[30:0];
          CFG_MASS:        m_q      <= cfg_data_i[30:0];
          CFG_DAMPING:     d_q      <= cfg_data_i[30:0];
          CFG_REST_LENGTH: l_q      <= cfg_data_i[30:0];
          CFG_GROUND_K:    kc_q     <= cfg_data_i[30:0];
          CFG_TIME_STEP:   dt_q     <= cfg_data_i[16:0];
          CFG_METHOD:      method_q <= cfg_data_i[2:0];
          CFG_GROUND_EN:   gnd_en_q <= cfg_data_i[0];
          default:         ;
        endcase
      end
      // sticky clamp flag
      if (cmd_i.clr) begin
        sat_q <= 1'b0;
      end else if (wr_en && wr_res.flag) begin
        sat_q <= 1'b1;
      end
      // state load and write back
      if (cmd_i.load) begin
        p_q    <= load_pos_i;
        v_q    <= load_vel_i;
        prev_q <= load_prev_pos_i;
      end else if (wr_en) begin
        unique case (u.dst)
          DST_P:    p_q    <= wr_res.val;
          DST_V:    v_q    <= wr_res.val;
          DST_PREV: prev_q <= wr_res.val;
          default:  ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_val) * 64'(b_val);
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    if (cmd_i.capture) begin
      anch_q <= anchor_pos_i;
    end
    if (wr_en) begin
      unique case (u.dst)
        DST_T0:  t0_q <= wr_res.val;
        DST_T1:  t1_q <= wr_res.val;
        DST_T2:  t2_q <= wr_res.val;
        DST_T3:  t3_q <= wr_res.val;
        DST_T4:  t4_q <= wr_res.val;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      pos_q    <= p_q;
      vel_q    <= v_q;
      satout_q <= sat_q;
    end
  end

  assign sts_o.done   = done_q;
  assign sts_o.method = method_q;
  assign position_o   = pos_q;
  assign velocity_o   = vel_q;
  assign saturated_o  = satout_q;

endmodule

// ===== sv/hmsi_ctrl.sv =====
// hmsi_ctrl.sv: controller that walks the micro-program and runs the handshakes
`timescale 1ns / 1ps

module hmsi_ctrl import hmsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     command_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       oval_q, oval_d;
  logic       accept;
  logic       runs;
  uop_t       u;

  assign u      = prog_uop(sts_i.method, step_q);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign runs   = (sts_i.method == METH_EXPLICIT) || (sts_i.method == METH_SYMPLECTIC) ||
                  (sts_i.method == METH_MIDPOINT) || (sts_i.method == METH_IMPLICIT) ||
                  (sts_i.method == METH_VERLET);

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.uop = u;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          cmd_o.clr     = 1'b1;
          step_d        = '0;
          if (command_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
            state_d    = ST_RESULT;
          end else if (runs) begin
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.done) begin
          if (u.last) begin
            state_d = ST_RESULT;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_RESULT: begin
        if (!oval_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          oval_d     = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      oval_q  <= oval_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = oval_q;

endmodule

// ===== sv/hanging_mass_spring_integrator.sv =====
// hanging_mass_spring_integrator.sv: top level of the hanging mass spring integrator
//
//   channel | handshake               | beat contents
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | command, anchor_pos, load_pos, load_vel,
//           |                         | load_prev_pos
//   out     | out_valid_o/out_stall_i | position, velocity, saturated
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A step runs a micro-program on one shared adder, one 32x32 multiplier and a
// bit-serial divider, one op at a time. A load or a hold skips the micro-program.
// Reset clears the state to zero and loads the register defaults.
// A finished beat waits in the output register while the next beat is taken;
// with a beat still waiting, the next result holds until it is taken.
`timescale 1ns / 1ps

module hanging_mass_spring_integrator import hmsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic signed [31:0] anchor_pos_i,
  input  logic signed [31:0] load_pos_i,
  input  logic signed [31:0] load_vel_i,
  input  logic signed [31:0] load_prev_pos_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  hmsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hmsi_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .anchor_pos_i    (anchor_pos_i),
    .load_pos_i      (load_pos_i),
    .load_vel_i      (load_vel_i),
    .load_prev_pos_i (load_prev_pos_i),
    .position_o      (position_o),
    .velocity_o      (velocity_o),
    .saturated_o     (saturated_o)
  );

endmodule

// ===== sim/hanging_mass_spring_integrator_test.sv =====
// hanging_mass_spring_integrator_test.sv: self-checking bench for the spring integrator
`timescale 1ns / 1ps

module hanging_mass_spring_integrator_test;
  import hmsi_pkg::*;

  localparam logic [2:0] METH_HOLD_ZERO = 3'd0;
  localparam logic [2:0] METH_HOLD_SIX  = 3'd6;
  localparam logic [2:0] METH_HOLD_TOP  = 3'd7;
  localparam longint     FIX_MAX        = 64'sd2147483647;
  localparam longint     FIX_MIN        = -64'sd2147483648;
  localparam longint     GRAVITY_FIX    = (981 * (64'sd1 <<< FRAC_BITS) + 50) / 100;
  localparam int         N_PHASES       = 20;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
  } mass_state_t;

  typedef struct {
    logic               cmd;
    logic signed [31:0] anchor;
    logic signed [31:0] lpos;
    logic signed [31:0] lvel;
    logic signed [31:0] lprev;
    logic               typed;
    mass_state_t        want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic signed [31:0] anchor_pos_i;
  logic signed [31:0] load_pos_i;
  logic signed [31:0] load_vel_i;
  logic signed [31:0] load_prev_pos_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] position_o;
  logic signed [31:0] velocity_o;
  logic               saturated_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  hanging_mass_spring_integrator u_top (.*);

  // predictor copy of registers and state
  longint k_reg, m_reg, d_reg, len_reg, kc_reg, dt_reg, meth_reg, gnd_reg;
  longint cur_pos, cur_vel, cur_prev;
  logic   clamped;

  mass_state_t next_state_q[$];
  int          n_errors, n_checked, n_loads, n_steps, n_sat;
  int          n_method[8];
  int          stall_left, stall_mode, mode_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fixed point arithmetic with clamp tracking
  function automatic longint clamp32(longint x);
    if (x > FIX_MAX) begin
      clamped = 1'b1;
      return FIX_MAX;
    end
    if (x < FIX_MIN) begin
      clamped = 1'b1;
      return FIX_MIN;
    end
    return x;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp32(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp32(a - b);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint prod;
    prod = a * b;
    return clamp32(prod >>> FRAC_BITS);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) begin
      if (a == 0) return 0;
      clamped = 1'b1;
      return (a > 0) ? FIX_MAX : FIX_MIN;
    end
    return clamp32((a * (64'sd1 <<< FRAC_BITS)) / b);
  endfunction

  function automatic logic below_ground(longint p);
    return (gnd_reg != 0) && (p < 0);
  endfunction

  function automatic longint spring_force(longint p, longint v, longint anchor);
    longint f;
    f = fx_sub(0, fx_mul(m_reg, GRAVITY_FIX));
    f = fx_sub(f, fx_mul(k_reg, fx_add(fx_sub(p, anchor), len_reg)));
    f = fx_sub(f, fx_mul(d_reg, v));
    if (below_ground(p)) f = fx_sub(f, fx_mul(kc_reg, p));
    return f;
  endfunction

  // expected state after one item, updates the predictor state
  function automatic mass_state_t predict_item(logic cmd, longint anchor, longint lp,
                                               longint lv, longint lpp);
    longint      p, v, dt, acc, h, vm, pm, acc2, f, md, st, coef, num, np, old;
    mass_state_t r;
    p = cur_pos;
    v = cur_vel;
    dt = dt_reg;
    clamped = 1'b0;
    if (cmd == CMD_LOAD) begin
      cur_pos = lp;
      cur_vel = lv;
      cur_prev = lpp;
    end else begin
      case (meth_reg[2:0])
        METH_EXPLICIT: begin
          acc = fx_div(spring_force(p, v, anchor), m_reg);
          cur_pos = fx_add(p, fx_mul(dt, v));
          cur_vel = fx_add(v, fx_mul(dt, acc));
        end
        METH_SYMPLECTIC: begin
          acc = fx_div(spring_force(p, v, anchor), m_reg);
          cur_vel = fx_add(v, fx_mul(dt, acc));
          cur_pos = fx_add(p, fx_mul(dt, cur_vel));
        end
        METH_MIDPOINT: begin
          h = dt >>> 1;
          acc = fx_div(spring_force(p, v, anchor), m_reg);
          vm = fx_add(v, fx_mul(h, acc));
          pm = fx_add(p, fx_mul(h, v));
          acc2 = fx_div(spring_force(pm, vm, anchor), m_reg);
          cur_pos = fx_add(p, fx_mul(dt, vm));
          cur_vel = fx_add(v, fx_mul(dt, acc2));
        end
        METH_IMPLICIT: begin
          f = spring_force(p, v, anchor);
          md = fx_add(m_reg, fx_mul(dt, d_reg));
          st = k_reg;
          if (below_ground(p)) st = fx_add(st, kc_reg);
          coef = fx_add(md, fx_mul(fx_mul(dt, dt), st));
          num = fx_add(fx_mul(md, v), fx_mul(dt, f));
          cur_vel = fx_div(num, coef);
          cur_pos = fx_add(p, fx_mul(dt, cur_vel));
        end
        METH_VERLET: begin
          old = cur_prev;
          acc = fx_div(spring_force(p, v, anchor), m_reg);
          np = fx_add(fx_sub(fx_add(p, p), old), fx_mul(fx_mul(dt, dt), acc));
          cur_vel = fx_div(fx_sub(np, old), dt + dt);
          cur_pos = np;
          cur_prev = p;
        end
        default: ;
      endcase
    end
    r.pos = cur_pos[31:0];
    r.vel = cur_vel[31:0];
    r.sat = clamped;
    return r;
  endfunction

  // register write over the configuration port
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_STIFFNESS:   k_reg    = data[30:0];
      CFG_MASS:        m_reg    = data[30:0];
      CFG_DAMPING:     d_reg    = data[30:0];
      CFG_REST_LENGTH: len_reg  = data[30:0];
      CFG_GROUND_K:    kc_reg   = data[30:0];
      CFG_TIME_STEP:   dt_reg   = data[16:0];
      CFG_METHOD:      meth_reg = data[2:0];
      CFG_GROUND_EN:   gnd_reg  = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(logic [30:0] k, logic [30:0] m, logic [30:0] d, logic [30:0] len,
                           logic [30:0] kc, logic [16:0] dt, logic [2:0] meth, logic gnd);
    // upper bits carry junk that the block must ignore
    write_reg(CFG_STIFFNESS,   {1'($urandom), k});
    write_reg(CFG_MASS,        {1'($urandom), m});
    write_reg(CFG_DAMPING,     {1'($urandom), d});
    write_reg(CFG_REST_LENGTH, {1'($urandom), len});
    write_reg(CFG_GROUND_K,    {1'($urandom), kc});
    write_reg(CFG_TIME_STEP,   {15'($urandom), dt});
    write_reg(CFG_METHOD,      {29'($urandom), meth});
    write_reg(CFG_GROUND_EN,   {31'($urandom), gnd});
  endtask

  // wait until every expected beat is out and the block has settled
  task automatic wait_drained();
    while (next_state_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // one input beat; valid is left high for a following beat
  task automatic send_beat(stim_row_t row);
    mass_state_t exp_st;
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    command_i       = row.cmd;
    anchor_pos_i    = row.anchor;
    load_pos_i      = row.lpos;
    load_vel_i      = row.lvel;
    load_prev_pos_i = row.lprev;
    do @(posedge clk_i); while (in_stall_o);
    exp_st = predict_item(row.cmd, row.anchor, row.lpos, row.lvel, row.lprev);
    if (row.typed) exp_st = row.want;
    next_state_q.push_back(exp_st);
    if (row.cmd == CMD_LOAD) n_loads++;
    else begin
      n_steps++;
      n_method[meth_reg[2:0]]++;
    end
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    r.typed = 1'b0;
    r.want  = '{default: '0};
    r.cmd   = ($urandom_range(0, 99) < 12) ? CMD_LOAD : CMD_STEP;
    r.anchor = ($urandom_range(0, 9) < 7) ? rand_value() : $urandom;
    r.lpos  = rand_value();
    r.lvel  = rand_value();
    r.lprev = rand_value();
    if (r.cmd == CMD_STEP && $urandom_range(0, 3) == 0) begin
      r.lpos = $urandom;
      r.lvel = $urandom;
      r.lprev = $urandom;
    end
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic cmd, logic signed [31:0] anc, logic signed [31:0] lp,
                                       logic signed [31:0] lv, logic signed [31:0] lpp,
                                       logic typed);
    stim_row_t r;
    r.cmd = cmd;
    r.anchor = anc;
    r.lpos = lp;
    r.lvel = lv;
    r.lprev = lpp;
    r.typed = typed;
    r.want.pos = lp;
    r.want.vel = lv;
    r.want.sat = 1'b0;
    return r;
  endfunction

  // receiver stall pattern: modes of free flow, random and long stalls
  initial begin
    out_stall_i = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(100, 2000);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i = 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = $urandom_range(0, 1);
          default: begin
            out_stall_i = ($urandom_range(0, 7) == 0);
            if (out_stall_i) stall_left = $urandom_range(1, 40);
          end
        endcase
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    mass_state_t exp_st;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (next_state_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected beat pos=%0d vel=%0d sat=%0b",
                   position_o, velocity_o, saturated_o);
      end else begin
        exp_st = next_state_q.pop_front();
        n_checked++;
        if (saturated_o) n_sat++;
        if (position_o !== exp_st.pos || velocity_o !== exp_st.vel ||
            saturated_o !== exp_st.sat) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: beat %0d pos %0d/%0d vel %0d/%0d sat %0b/%0b (exp/got)",
                     n_checked, exp_st.pos, position_o, exp_st.vel, velocity_o,
                     exp_st.sat, saturated_o);
        end
      end
    end
  end

  // run limit
  initial begin
    #60ms;
    $display("ERROR: timeout with %0d beats outstanding", next_state_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    int        n_items, burst, sel;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_STEP;
    anchor_pos_i = '0;
    load_pos_i = '0;
    load_vel_i = '0;
    load_prev_pos_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_STIFFNESS;
    cfg_data_i = '0;
    n_errors = 0;
    n_checked = 0;
    n_loads = 0;
    n_steps = 0;
    n_sat = 0;
    foreach (n_method[i]) n_method[i] = 0;
    k_reg = 65536;
    m_reg = 65536;
    d_reg = 0;
    len_reg = 65536;
    kc_reg = 0;
    dt_reg = 655;
    meth_reg = METH_EXPLICIT;
    gnd_reg = 0;
    cur_pos = 0;
    cur_vel = 0;
    cur_prev = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset defaults
    rows.push_back(mk_row(CMD_STEP, 0, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_LOAD, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1));
    rows.push_back(mk_row(CMD_STEP, 0, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_LOAD, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1));
    rows.push_back(mk_row(CMD_STEP, 32'sh80000000, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_LOAD, 32'sh7fffffff, 0, 0, 0, 1'b1));
    rows.push_back(mk_row(CMD_STEP, 32'sh7fffffff, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_LOAD, 0, 32'sh10000, -32'sh10000, 0, 1'b1));
    rows.push_back(mk_row(CMD_STEP, 0, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_STEP, 32'sh20000, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_STEP, -32'sh20000, 0, 0, 0, 1'b0));
    rows.push_back(mk_row(CMD_LOAD, 0, -32'sh10000, 32'sh55555555, -32'sh10000, 1'b1));
    rows.push_back(mk_row(CMD_LOAD, 0, 32'sh2aaaaaaa, -32'sh1, 32'sh1, 1'b1));
    rows.push_back(mk_row(CMD_STEP, 32'sh5a5a5a5a, 0, 0, 0, 1'b0));
    foreach (rows[i]) send_beat(rows[i]);
    idle_gap(0);
    wait_drained();

    // phases: holds, zero divisors, extremes, then random settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      n_items = 150;
      case (ph)
        0: begin write_all(65536, 65536, 0, 65536, 0, 655, METH_HOLD_ZERO, 0); n_items = 10; end
        1: begin write_all(65536, 65536, 0, 65536, 0, 655, METH_HOLD_SIX, 1); n_items = 10; end
        2: begin write_all(65536, 65536, 0, 65536, 0, 655, METH_HOLD_TOP, 0); n_items = 10; end
        // zero mass
        3: begin write_all(65536, 0, 0, 65536, 0, 655, METH_EXPLICIT, 0); n_items = 20; end
        // zero implicit coefficient
        4: begin write_all(0, 0, 0, 0, 0, 1, METH_IMPLICIT, 0); n_items = 20; end
        // zero step for the Verlet velocity
        5: begin write_all(65536, 65536, 0, 65536, 0, 0, METH_VERLET, 0); n_items = 20; end
        6: begin
          write_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                    17'h10000, METH_MIDPOINT, 1);
          n_items = 30;
        end
        7: begin write_all(0, 1, 0, 0, 0, 1, METH_VERLET, 0); n_items = 30; end
        default: begin
          sel = $urandom_range(0, 9);
          write_all(($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h40000)),
                    ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(32'h4000, 32'h40000)),
                    31'($urandom_range(0, 32'h8000)),
                    31'($urandom_range(0, 32'h30000)),
                    ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h100000)),
                    ($urandom_range(0, 4) == 0) ? 17'($urandom_range(1, 65536))
                                                : 17'($urandom_range(1, 6554)),
                    (sel == 0) ? METH_HOLD_ZERO : 3'(METH_EXPLICIT + (ph % 5)),
                    $urandom_range(0, 1));
        end
      endcase
      for (int i = 0; i < n_items; ) begin
        burst = (ph % 4 == 1) ? n_items : $urandom_range(1, 8);
        for (int b = 0; b < burst && i < n_items; b++, i++) begin
          r = rand_row();
          send_beat(r);
          // let the pipeline empty once with the sender held off
          if (ph == 10 && i == n_items / 2) begin
            idle_gap(0);
            wait_drained();
          end
        end
        idle_gap($urandom_range(0, 40));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (next_state_q.size() != 0) begin
      n_errors++;
      $display("ERROR: %0d expected beats never arrived", next_state_q.size());
    end
    $display("Checked %0d beats: %0d loads, %0d steps (%0d saturated), mismatches %0d",
             n_checked, n_loads, n_steps, n_sat, n_errors);
    $display("Steps by method 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", n_method[0], n_method[1],
             n_method[2], n_method[3], n_method[4], n_method[5], n_method[6], n_method[7]);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hmsi_pkg.sv
sv/hmsi_datapath.sv
sv/hmsi_ctrl.sv
sv/hanging_mass_spring_integrator.sv
sim/hanging_mass_spring_integrator_test.sv
